### rtl/core/udpb_pkg.sv
// Package for the UDP stream header builder.
// Holds widths, register indexes, fixed header constants and the mode table.
// No dependencies.
package udpb_pkg;

    // Widths of the channel fields
    localparam int STREAM_W   = 2;
    localparam int OFFSET_W   = 8;
    localparam int BYTE_W     = 8;

    // Slot layout
    localparam int HEADER_BYTES = 42;
    localparam int SLOT_BYTES   = 64;
    localparam int IDX_W        = $clog2(SLOT_BYTES);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_OWN_IP      = 3'd0;
    localparam t_cfg_idx REG_OWN_MAC     = 3'd1;
    localparam t_cfg_idx REG_TARGET_IP   = 3'd2;
    localparam t_cfg_idx REG_TARGET_PORT = 3'd3;
    localparam t_cfg_idx REG_TARGET_MAC  = 3'd4;
    localparam t_cfg_idx REG_STREAM_ON   = 3'd5;
    localparam t_cfg_idx REG_BUS_MODE    = 3'd6;

    typedef logic [STREAM_W-1:0] t_stream;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [BYTE_W-1:0]   t_byte;

    // Only this stream has a header slot
    localparam t_stream ACTIVE_STREAM = 2'd2;

    // Byte position of the control byte inside a slot, and its run index
    localparam t_idx CTRL_POS     = IDX_W'(SLOT_BYTES - 1);
    localparam t_idx CTRL_IDX     = IDX_W'(HEADER_BYTES);
    localparam t_idx LAST_HDR_IDX = IDX_W'(HEADER_BYTES - 1);

    // Sum of the fixed 16-bit words of the IPv4 header:
    // 4500 + 001C + BBBB + 4000 + 4011
    localparam logic [18:0] CSUM_BASE = 19'h180E8;

    // Low nibble of the control byte when the stream is enabled
    localparam logic [3:0] CTRL_ENABLE = 4'h4;

    // Mode nibble lookup
    function automatic logic [3:0] mode_nibble(input logic [2:0] mode);
        logic [3:0] nib;
        case (mode)
            3'd0:    nib = 4'h1;
            3'd1:    nib = 4'h2;
            3'd2:    nib = 4'h3;
            3'd3:    nib = 4'h4;
            3'd4:    nib = 4'h5;
            3'd5:    nib = 4'h9;
            3'd6:    nib = 4'hB;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

endpackage

### rtl/core/udpb_if.sv
// Channel interfaces of the UDP stream header builder: the rebuild request
// and the register write result. Depends on udpb_pkg.
interface udpb_req_if;
    import udpb_pkg::*;

    logic    valid;
    logic    ready;
    t_stream stream_num;

    modport source (output valid, output stream_num, input ready);
    modport sink   (input valid, input stream_num, output ready);
endinterface

interface udpb_wr_if;
    import udpb_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] write_offset;
    t_byte               write_byte;
    logic                last_write;

    modport source (output valid, output write_offset, output write_byte,
                     output last_write, input ready);
    modport sink   (input valid, input write_offset, input write_byte,
                     input last_write, output ready);
endinterface

### rtl/core/udp_stream_header_builder_core.sv
// UDP stream header builder: one request for stream 2 yields 43 byte writes
// (42 header bytes, then the control byte), one per cycle while o_wr is ready;
// 1 write when the stream is disabled or own IP is zero; other streams are
// dropped with no write. Requests pass the request stage, writes the result
// stage; a new request is taken as the current one's last write is made.
// Synchronous active-low reset clears all configuration and both stages.
module udp_stream_header_builder_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  udpb_pkg::t_cfg_idx             i_cfg_addr,
    input  logic [udpb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    udpb_req_if.sink                       i_req,
    udpb_wr_if.source                      o_wr
);
    import udpb_pkg::*;

    // Configuration registers
    logic [31:0] r_own_ip;
    logic [47:0] r_own_mac;
    logic [31:0] r_target_ip;
    logic [15:0] r_target_port;
    logic [47:0] r_target_mac;
    logic        r_stream_on;
    logic [2:0]  r_bus_mode;

    // Request stage and byte counter
    logic    r_in_valid, n_in_valid;
    t_stream r_in_stream, n_in_stream;
    t_idx    r_idx, n_idx;

    // Result stage
    logic                r_out_valid, n_out_valid;
    logic [OFFSET_W-1:0] r_out_offset, n_out_offset;
    t_byte               r_out_byte, n_out_byte;
    logic                r_out_last, n_out_last;

    // Per-cycle control
    logic        out_free;
    logic        is_active;
    logic        short_run;
    logic        cur_last;
    logic        emit;
    logic        consume;
    logic        req_take;
    t_idx        cur_pos;
    t_byte       hdr_byte;
    t_byte       ctrl_byte;
    logic [47:0] dst_mac;
    logic [18:0] csum_sum;
    logic [16:0] csum_fold1;
    logic [15:0] csum_fold2;
    logic [15:0] ip_csum;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip      <= '0;
            r_own_mac     <= '0;
            r_target_ip   <= '0;
            r_target_port <= '0;
            r_target_mac  <= '0;
            r_stream_on   <= 1'b0;
            r_bus_mode    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_OWN_IP:      r_own_ip      <= i_cfg_wdata[31:0];
                REG_OWN_MAC:     r_own_mac     <= i_cfg_wdata[47:0];
                REG_TARGET_IP:   r_target_ip   <= i_cfg_wdata[31:0];
                REG_TARGET_PORT: r_target_port <= i_cfg_wdata[15:0];
                REG_TARGET_MAC:  r_target_mac  <= i_cfg_wdata[47:0];
                REG_STREAM_ON:   r_stream_on   <= i_cfg_wdata[0];
                REG_BUS_MODE:    r_bus_mode    <= i_cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    // Pick the destination MAC: multicast map 232.x-239.x, broadcast or unicast
    always_comb begin
        if (r_target_ip[7:3] == 5'b11101) begin
            dst_mac = {8'h01, 8'h00, 8'h5E, 1'b0, r_target_ip[14:8],
                       r_target_ip[23:16], r_target_ip[31:24]};
        end else if (r_target_ip == 32'hFFFF_FFFF) begin
            dst_mac = 48'hFFFF_FFFF_FFFF;
        end else begin
            dst_mac = r_target_mac;
        end
    end

    // IPv4 header checksum: add the address words to the fixed part, fold twice
    assign csum_sum = CSUM_BASE
                    + {3'b000, r_own_ip[7:0],     r_own_ip[15:8]}
                    + {3'b000, r_own_ip[23:16],   r_own_ip[31:24]}
                    + {3'b000, r_target_ip[7:0],   r_target_ip[15:8]}
                    + {3'b000, r_target_ip[23:16], r_target_ip[31:24]};
    assign csum_fold1 = {1'b0, csum_sum[15:0]} + {14'd0, csum_sum[18:16]};
    assign csum_fold2 = csum_fold1[15:0] + {15'd0, csum_fold1[16]};
    assign ip_csum    = ~csum_fold2;

    // Select the header byte at the current position
    always_comb begin
        case (r_idx)
            6'd0:    hdr_byte = dst_mac[47:40];
            6'd1:    hdr_byte = dst_mac[39:32];
            6'd2:    hdr_byte = dst_mac[31:24];
            6'd3:    hdr_byte = dst_mac[23:16];
            6'd4:    hdr_byte = dst_mac[15:8];
            6'd5:    hdr_byte = dst_mac[7:0];
            6'd6:    hdr_byte = r_own_mac[47:40];
            6'd7:    hdr_byte = r_own_mac[39:32];
            6'd8:    hdr_byte = r_own_mac[31:24];
            6'd9:    hdr_byte = r_own_mac[23:16];
            6'd10:   hdr_byte = r_own_mac[15:8];
            6'd11:   hdr_byte = r_own_mac[7:0];
            6'd12:   hdr_byte = 8'h08;
            6'd14:   hdr_byte = 8'h45;
            6'd17:   hdr_byte = 8'h1C;
            6'd18:   hdr_byte = 8'hBB;
            6'd19:   hdr_byte = 8'hBB;
            6'd20:   hdr_byte = 8'h40;
            6'd22:   hdr_byte = 8'h40;
            6'd23:   hdr_byte = 8'h11;
            6'd24:   hdr_byte = ip_csum[15:8];
            6'd25:   hdr_byte = ip_csum[7:0];
            6'd26:   hdr_byte = r_own_ip[7:0];
            6'd27:   hdr_byte = r_own_ip[15:8];
            6'd28:   hdr_byte = r_own_ip[23:16];
            6'd29:   hdr_byte = r_own_ip[31:24];
            6'd30:   hdr_byte = r_target_ip[7:0];
            6'd31:   hdr_byte = r_target_ip[15:8];
            6'd32:   hdr_byte = r_target_ip[23:16];
            6'd33:   hdr_byte = r_target_ip[31:24];
            6'd34:   hdr_byte = 8'h19;
            6'd35:   hdr_byte = 8'h6E;
            6'd36:   hdr_byte = r_target_port[15:8];
            6'd37:   hdr_byte = r_target_port[7:0];
            6'd39:   hdr_byte = 8'h08;
            default: hdr_byte = 8'h00;
        endcase
    end

    // Run control: drop other streams, walk the slot for the active one
    assign out_free  = !r_out_valid || o_wr.ready;
    assign is_active = (r_in_stream == ACTIVE_STREAM);
    assign short_run = (r_own_ip == 32'd0) || !r_stream_on;
    assign cur_last  = short_run || (r_idx == CTRL_IDX);
    assign emit      = r_in_valid && is_active && out_free;
    assign consume   = r_in_valid && (!is_active || (out_free && cur_last));
    assign req_take  = i_req.valid && i_req.ready;
    assign cur_pos   = cur_last ? CTRL_POS : r_idx;
    assign ctrl_byte = short_run ? 8'h00 : {mode_nibble(r_bus_mode), CTRL_ENABLE};

    assign i_req.ready = !r_in_valid || consume;

    // Next state of the request stage and counter
    always_comb begin
        n_in_valid  = r_in_valid;
        n_in_stream = r_in_stream;
        n_idx       = r_idx;
        if (consume) begin
            n_in_valid = 1'b0;
            n_idx      = '0;
        end else if (emit) begin
            n_idx = r_idx + 1'b1;
        end
        if (req_take) begin
            n_in_valid  = 1'b1;
            n_in_stream = i_req.stream_num;
        end
    end

    // Next state of the result stage
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_offset = r_out_offset;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_offset = {r_in_stream, cur_pos};
            n_out_byte   = cur_last ? ctrl_byte : hdr_byte;
            n_out_last   = cur_last;
        end else if (o_wr.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_in_stream  <= n_in_stream;
        r_out_offset <= n_out_offset;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
    end

    assign o_wr.valid        = r_out_valid;
    assign o_wr.write_offset = r_out_offset;
    assign o_wr.write_byte   = r_out_byte;
    assign o_wr.last_write   = r_out_last;

endmodule

### rtl/core/udpb_checker.sv
// Port-level checker for the UDP stream header builder, bound to its top level.
// Depends on udpb_pkg and udp_stream_header_builder_core.
module udpb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_wr_valid,
    input logic                          i_wr_ready,
    input logic [udpb_pkg::OFFSET_W-1:0] i_wr_offset,
    input logic                          i_wr_last
);
    import udpb_pkg::*;

    localparam logic [OFFSET_W-1:0] CTRL_OFF     = {ACTIVE_STREAM, CTRL_POS};
    localparam logic [OFFSET_W-1:0] LAST_HDR_OFF = {ACTIVE_STREAM, LAST_HDR_IDX};

    logic wr_take;
    assign wr_take = i_wr_valid && i_wr_ready;

    // No write is pending after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_wr_valid)
        else $error("write valid after reset");

    // Only the active slot is written, and the control byte closes each run
    a_slot_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_valid |-> (i_wr_offset[OFFSET_W-1:IDX_W] == ACTIVE_STREAM) &&
                       (i_wr_last == (i_wr_offset == CTRL_OFF)))
        else $error("write outside active slot or misplaced last flag");

    // Header writes stay inside the header area
    a_hdr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_valid && !i_wr_last) |-> (i_wr_offset[IDX_W-1:0] < CTRL_IDX))
        else $error("header write beyond header area");

    // Advance through the header without gaps, then the control byte
    a_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_take && !i_wr_last) |=> i_wr_valid &&
            ((i_wr_offset == $past(i_wr_offset) + 8'd1) ||
             (($past(i_wr_offset) == LAST_HDR_OFF) && i_wr_last)))
        else $error("header writes out of order");

endmodule

bind udp_stream_header_builder_core udpb_checker u_udpb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_wr_valid  (o_wr.valid),
    .i_wr_ready  (o_wr.ready),
    .i_wr_offset (o_wr.write_offset),
    .i_wr_last   (o_wr.last_write)
);
